### rtl/tlru_pkg.sv
// ----------------------------------------------------------------------------
// tlru_pkg: shared types and codes
// Command, status and code types used by the two-tier LRU core and its tiers.
// ----------------------------------------------------------------------------
package tlru_pkg;

  localparam int KEY_W = 64;
  localparam int CNT_W = 32;

  // Configuration register indexes.
  localparam logic [7:0] CFG_FAST_CAP = 8'd0;
  localparam logic [7:0] CFG_SLOW_CAP = 8'd1;

  typedef enum logic [1:0] {
    WHERE_MISS = 2'd0,
    WHERE_FAST = 2'd1,
    WHERE_SLOW = 2'd2
  } where_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FIND,
    OP_SEGOF,
    OP_REMOVE,
    OP_DROP,
    OP_PUSH,
    OP_REBAL
  } tier_op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_LOAD
  } cell_ctl_t;

  typedef struct packed {
    tier_op_t           op;
    logic [KEY_W-1:0]   key;
  } tier_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
    logic drop_hit;
  } tier_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_F_SEGOF,
    ST_F_REMOVE,
    ST_F_PUSH,
    ST_F_REBAL,
    ST_S_SEGOF,
    ST_S_REMOVE,
    ST_S_REBAL_RM,
    ST_F_DROP,
    ST_S_DROP,
    ST_S_PUSH,
    ST_S_REBAL,
    ST_FIN
  } state_t;

endpackage

### rtl/tlru_cell.sv
// ----------------------------------------------------------------------------
// tlru_cell: one recency slot
// Holds one key, moves it to or from its neighbors and compares it.
// ----------------------------------------------------------------------------
module tlru_cell
  import tlru_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] from_left,
  input  logic [KEY_W-1:0] from_right,
  input  logic [KEY_W-1:0] load_key,
  input  logic [KEY_W-1:0] cmp_key,
  output logic [KEY_W-1:0] key_q,
  output logic             match
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;

  always_comb begin
    unique case (ctl)
      CELL_HOLD:  key_nxt = key_r;
      CELL_LEFT:  key_nxt = from_left;
      CELL_RIGHT: key_nxt = from_right;
      CELL_LOAD:  key_nxt = load_key;
      default:    key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;
  assign match = (key_r == cmp_key);

endmodule

### rtl/tlru_tier.sv
// ----------------------------------------------------------------------------
// tlru_tier: one recency-ordered tier
// A row of key cells plus segment sizes, running one primitive command at a time.
// ----------------------------------------------------------------------------
module tlru_tier
  import tlru_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int SEGS  = 10,
  parameter int CAPW  = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tier_cmd_t                 cmd,
  input  logic [CAPW-1:0]           cap,
  output tier_sts_t                 sts,
  output logic [$clog2(SEGS)-1:0]   seg_of,
  output logic [KEY_W-1:0]          drop_key
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(SEGS);
  localparam int MW = ((CW > CAPW) ? CW : CAPW) + 1;

  logic [KEY_W-1:0] key_q [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] hit_vec;
  cell_ctl_t        ctl   [DEPTH];

  logic [CW-1:0] seg_r   [SEGS];
  logic [CW-1:0] seg_nxt [SEGS];
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] q_r, q_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] carry_r, carry_nxt;
  logic [SW-1:0] segof_r, segof_nxt;
  logic [AW-1:0] pos_r, pos_nxt;

  logic [AW-1:0] pos_c;
  logic          any_hit;
  logic [SW-1:0] last_nz;
  logic [SW-1:0] rd_idx;
  logic [CW-1:0] seg_rd;
  logic [CW-1:0] sum;
  logic [CW-1:0] v;
  logic [CW-1:0] lim;
  logic          can_push;
  logic          drop_hit;
  logic          inc, dec, done;
  logic [MW-1:0] tot_w, cap_w, dep_w, capeff;
  logic [AW-1:0] last_idx;

  // Key cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_k;
    logic [KEY_W-1:0] right_k;
    assign left_k  = (i == 0) ? cmd.key : key_q[(i == 0) ? 0 : i - 1];
    assign right_k = key_q[(i == DEPTH - 1) ? i : i + 1];

    always_comb begin
      ctl[i] = CELL_HOLD;
      if (cmd.op == OP_PUSH && can_push) begin
        ctl[i] = (i == 0) ? CELL_LOAD : CELL_LEFT;
      end else if (cmd.op == OP_REMOVE && AW'(i) >= pos_r) begin
        ctl[i] = CELL_RIGHT;
      end
    end

    tlru_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .from_left (left_k),
      .from_right(right_k),
      .load_key  (cmd.key),
      .cmp_key   (cmd.key),
      .key_q     (key_q[i]),
      .match     (cell_match[i])
    );

    assign hit_vec[i] = cell_match[i] && (CW'(i) < total_r);
  end

  // Keys in a tier are distinct, so at most one cell hits.
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) pos_c = pos_c | AW'(i);
    end
  end
  assign any_hit = |hit_vec;

  always_comb begin
    last_nz = '0;
    for (int s = 0; s < SEGS; s++) begin
      if (seg_r[s] != '0) last_nz = SW'(s);
    end
  end

  assign tot_w    = MW'(total_r);
  assign cap_w    = MW'(cap);
  assign dep_w    = MW'(DEPTH);
  assign capeff   = (cap_w > dep_w) ? dep_w : cap_w;
  assign drop_hit = (tot_w >= capeff) && (total_r != '0);
  assign can_push = (total_r < CW'(DEPTH));
  assign last_idx = AW'(total_r - CW'(1));
  assign drop_key = key_q[last_idx];

  always_comb begin
    unique case (cmd.op)
      OP_DROP:   rd_idx = last_nz;
      OP_REMOVE: rd_idx = segof_r;
      default:   rd_idx = step_r;
    endcase
  end
  assign seg_rd = seg_r[rd_idx];
  assign sum    = acc_r + seg_rd;
  assign v      = seg_rd + carry_r;
  assign lim    = ((q_r == '0) ? CW'(1) : q_r) + CW'(1);

  always_comb begin
    seg_nxt   = seg_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    segof_nxt = segof_r;
    pos_nxt   = pos_r;
    inc       = 1'b0;
    dec       = 1'b0;
    done      = 1'b0;
    unique case (cmd.op)
      OP_NOP: begin
      end
      OP_FIND: begin
        pos_nxt = pos_c;
        done    = 1'b1;
      end
      OP_SEGOF: begin
        if (CW'(pos_r) < sum || step_r == SW'(SEGS - 1)) begin
          segof_nxt = step_r;
          step_nxt  = '0;
          acc_nxt   = '0;
          done      = 1'b1;
        end else begin
          step_nxt = step_r + SW'(1);
          acc_nxt  = sum;
        end
      end
      OP_REMOVE: begin
        if (seg_rd != '0) begin
          seg_nxt[segof_r] = seg_rd - CW'(1);
          dec              = 1'b1;
        end
        done = 1'b1;
      end
      OP_DROP: begin
        if (drop_hit) begin
          seg_nxt[last_nz] = seg_rd - CW'(1);
          dec              = 1'b1;
        end
        done = 1'b1;
      end
      OP_PUSH: begin
        if (can_push) begin
          seg_nxt[0] = seg_r[0] + CW'(1);
          inc        = 1'b1;
        end
        done = 1'b1;
      end
      OP_REBAL: begin
        // The overflow of each segment is carried into the next one.
        if (step_r == SW'(SEGS - 1)) begin
          seg_nxt[step_r] = v;
          carry_nxt       = '0;
          step_nxt        = '0;
          done            = 1'b1;
        end else begin
          if (v > lim) begin
            seg_nxt[step_r] = lim;
            carry_nxt       = v - lim;
          end else begin
            seg_nxt[step_r] = v;
            carry_nxt       = '0;
          end
          step_nxt = step_r + SW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy is kept as total and as quotient and remainder by the segment count.
  always_comb begin
    total_nxt = total_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    if (inc) begin
      total_nxt = total_r + CW'(1);
      if (rem_r == SW'(SEGS - 1)) begin
        q_nxt   = q_r + CW'(1);
        rem_nxt = '0;
      end else begin
        rem_nxt = rem_r + SW'(1);
      end
    end else if (dec) begin
      total_nxt = total_r - CW'(1);
      if (rem_r == '0) begin
        q_nxt   = q_r - CW'(1);
        rem_nxt = SW'(SEGS - 1);
      end else begin
        rem_nxt = rem_r - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SEGS; s++) seg_r[s] <= '0;
      total_r <= '0;
      q_r     <= '0;
      rem_r   <= '0;
      step_r  <= '0;
      acc_r   <= '0;
      carry_r <= '0;
      segof_r <= '0;
      pos_r   <= '0;
    end else begin
      seg_r   <= seg_nxt;
      total_r <= total_nxt;
      q_r     <= q_nxt;
      rem_r   <= rem_nxt;
      step_r  <= step_nxt;
      acc_r   <= acc_nxt;
      carry_r <= carry_nxt;
      segof_r <= segof_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign sts.done     = done;
  assign sts.found    = any_hit;
  assign sts.drop_hit = drop_hit;
  assign seg_of       = segof_r;

endmodule

### rtl/two_tier_lru_with_deciles_core.sv
// ----------------------------------------------------------------------------
// two_tier_lru_with_deciles_core: exclusive two-tier LRU cache with deciles
// Looks up one key per transaction and reports tier, decile and dropped key.
// ----------------------------------------------------------------------------
// Each tier is a row of key cells, most recent first, searched in parallel
// and shifted one slot per cycle as keys are inserted or removed. A
// sequencer runs one transaction at a time: lookup, segment lookup of the
// hit, removal, insertion and rebalancing of the segment sizes. Segment
// lookup and rebalancing each walk the segments one per cycle. A finished
// result sits in the output register, so the next transaction is taken
// while it waits. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module two_tier_lru_with_deciles_core
  import tlru_pkg::*;
#(
  parameter int FAST_DEPTH    = 32,
  parameter int SLOW_DEPTH    = 256,
  parameter int SEGMENT_COUNT = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] in_obj_key,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_where_found,
  output logic [3:0]       out_hit_decile,
  output logic             out_dropped_valid,
  output logic [KEY_W-1:0] out_dropped_key,
  output logic [CNT_W-1:0] out_fast_hit_total,
  output logic [CNT_W-1:0] out_slow_hit_total,
  output logic [CNT_W-1:0] out_miss_total,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_index,
  input  logic [8:0]       cfg_wdata
);

  localparam int SW = $clog2(SEGMENT_COUNT);

  state_t state_r, state_nxt;

  tier_cmd_t        fcmd, scmd;
  tier_sts_t        fsts, ssts;
  logic [SW-1:0]    fseg, sseg;
  logic [KEY_W-1:0] fdrop_key, sdrop_key;

  logic [5:0]       fast_cap_r;
  logic [8:0]       slow_cap_r;
  logic [KEY_W-1:0] key_r;
  where_t           where_r;
  logic [3:0]       decile_r;
  logic             demote_v_r;
  logic [KEY_W-1:0] demoted_r;
  logic             dvalid_r;
  logic [KEY_W-1:0] dkey_r;
  logic [CNT_W-1:0] fast_cnt_r, slow_cnt_r, miss_cnt_r;

  logic             out_valid_r;
  logic [1:0]       out_where_r;
  logic [3:0]       out_decile_r;
  logic             out_dvalid_r;
  logic [KEY_W-1:0] out_dkey_r;
  logic [CNT_W-1:0] out_fast_r, out_slow_r, out_miss_r;

  logic [4:0] fdec_w, sdec_w;
  logic       in_take, out_free;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign fdec_w   = 5'(fseg) + 5'd1;
  assign sdec_w   = 5'(sseg) + 5'd1;

  tlru_tier #(.DEPTH(FAST_DEPTH), .SEGS(SEGMENT_COUNT), .CAPW(6)) u_fast (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (fcmd),
    .cap     (fast_cap_r),
    .sts     (fsts),
    .seg_of  (fseg),
    .drop_key(fdrop_key)
  );

  tlru_tier #(.DEPTH(SLOW_DEPTH), .SEGS(SEGMENT_COUNT), .CAPW(9)) u_slow (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (scmd),
    .cap     (slow_cap_r),
    .sts     (ssts),
    .seg_of  (sseg),
    .drop_key(sdrop_key)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_take) state_nxt = ST_FIND;
      ST_FIND: begin
        if (fsts.found)      state_nxt = ST_F_SEGOF;
        else if (ssts.found) state_nxt = ST_S_SEGOF;
        else                 state_nxt = ST_S_DROP;
      end
      ST_F_SEGOF:    if (fsts.done) state_nxt = ST_F_REMOVE;
      ST_F_REMOVE:   state_nxt = ST_F_PUSH;
      ST_F_PUSH:     state_nxt = ST_F_REBAL;
      ST_F_REBAL: begin
        if (fsts.done) begin
          state_nxt = (where_r == WHERE_SLOW && demote_v_r) ? ST_S_DROP : ST_FIN;
        end
      end
      ST_S_SEGOF:    if (ssts.done) state_nxt = ST_S_REMOVE;
      ST_S_REMOVE:   state_nxt = ST_S_REBAL_RM;
      ST_S_REBAL_RM: if (ssts.done) state_nxt = ST_F_DROP;
      ST_F_DROP:     state_nxt = ST_F_PUSH;
      ST_S_DROP:     state_nxt = ST_S_PUSH;
      ST_S_PUSH:     state_nxt = ST_S_REBAL;
      ST_S_REBAL:    if (ssts.done) state_nxt = ST_FIN;
      ST_FIN:        if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Tier commands for each state.
  always_comb begin
    fcmd.op  = OP_NOP;
    fcmd.key = key_r;
    scmd.op  = OP_NOP;
    scmd.key = (where_r == WHERE_MISS) ? key_r : demoted_r;
    unique case (state_r)
      ST_FIND: begin
        fcmd.op  = OP_FIND;
        scmd.op  = OP_FIND;
        scmd.key = key_r;
      end
      ST_F_SEGOF:    fcmd.op = OP_SEGOF;
      ST_F_REMOVE:   fcmd.op = OP_REMOVE;
      ST_F_PUSH:     fcmd.op = OP_PUSH;
      ST_F_REBAL:    fcmd.op = OP_REBAL;
      ST_F_DROP:     fcmd.op = OP_DROP;
      ST_S_SEGOF:    scmd.op = OP_SEGOF;
      ST_S_REMOVE:   scmd.op = OP_REMOVE;
      ST_S_REBAL_RM: scmd.op = OP_REBAL;
      ST_S_DROP:     scmd.op = OP_DROP;
      ST_S_PUSH:     scmd.op = OP_PUSH;
      ST_S_REBAL:    scmd.op = OP_REBAL;
      default: begin
      end
    endcase
  end

  // Control state, counters and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fast_cap_r  <= 6'd32;
      slow_cap_r  <= 9'd256;
      fast_cnt_r  <= '0;
      slow_cnt_r  <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      where_r     <= WHERE_MISS;
      demote_v_r  <= 1'b0;
      dvalid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en && cfg_index == CFG_FAST_CAP) fast_cap_r <= cfg_wdata[5:0];
      if (cfg_wr_en && cfg_index == CFG_SLOW_CAP) slow_cap_r <= cfg_wdata;
      // A new result is loaded when the register is free; otherwise a taken
      // result empties it.
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            demote_v_r <= 1'b0;
            dvalid_r   <= 1'b0;
          end
        end
        ST_FIND: begin
          if (fsts.found) begin
            where_r    <= WHERE_FAST;
            fast_cnt_r <= (fast_cnt_r == '1) ? fast_cnt_r : fast_cnt_r + 1'b1;
          end else if (ssts.found) begin
            where_r    <= WHERE_SLOW;
            slow_cnt_r <= (slow_cnt_r == '1) ? slow_cnt_r : slow_cnt_r + 1'b1;
          end else begin
            where_r    <= WHERE_MISS;
            miss_cnt_r <= (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + 1'b1;
          end
        end
        ST_F_DROP: demote_v_r <= fsts.drop_hit;
        ST_S_DROP: if (ssts.drop_hit) dvalid_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Payload registers. The segment of a hit is registered inside the tier
  // at the end of its walk, so it is picked up in the removal state.
  always_ff @(posedge clk) begin
    if (in_take) begin
      key_r    <= in_obj_key;
      decile_r <= '0;
      dkey_r   <= '0;
    end
    if (state_r == ST_F_REMOVE) decile_r <= fdec_w[3:0];
    if (state_r == ST_S_REMOVE) decile_r <= sdec_w[3:0];
    if (state_r == ST_F_DROP) demoted_r <= fdrop_key;
    if (state_r == ST_S_DROP && ssts.drop_hit) dkey_r <= sdrop_key;
    if (state_r == ST_FIN && out_free) begin
      out_where_r  <= where_r;
      out_decile_r <= decile_r;
      out_dvalid_r <= dvalid_r;
      out_dkey_r   <= dkey_r;
      out_fast_r   <= fast_cnt_r;
      out_slow_r   <= slow_cnt_r;
      out_miss_r   <= miss_cnt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_where_found    = out_where_r;
  assign out_hit_decile     = out_decile_r;
  assign out_dropped_valid  = out_dvalid_r;
  assign out_dropped_key    = out_dkey_r;
  assign out_fast_hit_total = out_fast_r;
  assign out_slow_hit_total = out_slow_r;
  assign out_miss_total     = out_miss_r;

endmodule

### rtl/tlru_checker.sv
// ----------------------------------------------------------------------------
// tlru_port_checks: port-level checks
// Watches the ports of the core and flags broken transactions.
// ----------------------------------------------------------------------------
module tlru_port_checks
  import tlru_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [KEY_W-1:0] in_obj_key,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       out_where_found,
  input logic [3:0]       out_hit_decile,
  input logic             out_dropped_valid,
  input logic [KEY_W-1:0] out_dropped_key,
  input logic [CNT_W-1:0] out_fast_hit_total,
  input logic [CNT_W-1:0] out_slow_hit_total,
  input logic [CNT_W-1:0] out_miss_total,
  input logic             cfg_wr_en,
  input logic [7:0]       cfg_index,
  input logic [8:0]       cfg_wdata
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The core works on one transaction at a time.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_miss_decile: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_where_found == WHERE_MISS |-> out_hit_decile == 4'd0)
    else $error("decile reported on a miss");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dropped_valid |-> out_dropped_key == '0)
    else $error("dropped key without a drop");

endmodule

bind two_tier_lru_with_deciles_core tlru_port_checks u_tlru_port_checks (.*);

### sim/tlru_checker.sv
// ----------------------------------------------------------------------------
// tlru_checker: result predictor and scoreboard for the two-tier LRU core
// Watches the lookup, result and configuration ports, predicts every result
// from its own copy of both tiers and compares the results field by field.
// ----------------------------------------------------------------------------
module tlru_checker
  import tlru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [KEY_W-1:0] in_obj_key,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_where_found,
  input  logic [3:0]       out_hit_decile,
  input  logic             out_dropped_valid,
  input  logic [KEY_W-1:0] out_dropped_key,
  input  logic [CNT_W-1:0] out_fast_hit_total,
  input  logic [CNT_W-1:0] out_slow_hit_total,
  input  logic [CNT_W-1:0] out_miss_total,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_index,
  input  logic [8:0]       cfg_wdata,
  output int               pending,
  output int               fail_count
);

  localparam int SEGS   = 10;
  localparam int MAXD   = 256;
  localparam int FAST_T = 0;
  localparam int SLOW_T = 1;

  typedef struct {
    where_t           where;
    logic [3:0]       decile;
    logic             drop_v;
    logic [KEY_W-1:0] drop_k;
    logic [CNT_W-1:0] fast_n;
    logic [CNT_W-1:0] slow_n;
    logic [CNT_W-1:0] miss_n;
  } lookup_result_t;

  logic [KEY_W-1:0] tier_keys [2][MAXD];
  int               tier_seg  [2][SEGS];
  int               tier_depth[2];
  int               fast_cap, slow_cap;
  logic [CNT_W-1:0] fast_hits, slow_hits, misses;
  lookup_result_t   awaited[$];

  function automatic int occupancy(int t);
    int sum;
    sum = 0;
    for (int s = 0; s < SEGS; s++) sum += tier_seg[t][s];
    return sum;
  endfunction

  function automatic void settle_segments(int t);
    int target;
    target = occupancy(t) / SEGS;
    if (target < 1) target = 1;
    for (int s = 0; s + 1 < SEGS; s++) begin
      while (tier_seg[t][s] > target + 1) begin
        tier_seg[t][s]--;
        tier_seg[t][s+1]++;
      end
    end
  endfunction

  function automatic int locate(int t, logic [KEY_W-1:0] key);
    int n;
    n = occupancy(t);
    for (int i = 0; i < n && i < tier_depth[t]; i++)
      if (tier_keys[t][i] == key) return i;
    return -1;
  endfunction

  function automatic int segment_at(int t, int pos);
    int acc;
    acc = 0;
    for (int s = 0; s < SEGS; s++) begin
      acc += tier_seg[t][s];
      if (pos < acc) return s;
    end
    return SEGS - 1;
  endfunction

  function automatic void take_out(int t, int pos);
    int n, s;
    n = occupancy(t);
    s = segment_at(t, pos);
    for (int i = pos; i + 1 < n; i++) tier_keys[t][i] = tier_keys[t][i+1];
    if (tier_seg[t][s] > 0) tier_seg[t][s]--;
  endfunction

  function automatic void put_front(int t, logic [KEY_W-1:0] key);
    int n;
    n = occupancy(t);
    if (n >= tier_depth[t]) return;
    for (int i = n; i > 0; i--) tier_keys[t][i] = tier_keys[t][i-1];
    tier_keys[t][0] = key;
    tier_seg[t][0]++;
  endfunction

  // Inserts at the front, first dropping the oldest key when at capacity.
  function automatic bit admit(int t, logic [KEY_W-1:0] key, int cap,
                               output logic [KEY_W-1:0] gone);
    int n;
    bit out;
    n = occupancy(t);
    out = 0;
    gone = '0;
    if (cap > tier_depth[t]) cap = tier_depth[t];
    if (n >= cap && n > 0) begin
      for (int s = SEGS - 1; s >= 0; s--) begin
        if (tier_seg[t][s] > 0) begin
          gone = tier_keys[t][n-1];
          tier_seg[t][s]--;
          out = 1;
          break;
        end
      end
    end
    put_front(t, key);
    settle_segments(t);
    return out;
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic lookup_result_t access(logic [KEY_W-1:0] key);
    lookup_result_t r;
    logic [KEY_W-1:0] demoted, gone;
    int pos;
    r.where  = WHERE_MISS;
    r.decile = '0;
    r.drop_v = 1'b0;
    r.drop_k = '0;
    gone     = '0;
    pos = locate(FAST_T, key);
    if (pos >= 0) begin
      r.where  = WHERE_FAST;
      r.decile = 4'(segment_at(FAST_T, pos) + 1);
      fast_hits = bump(fast_hits);
      take_out(FAST_T, pos);
      put_front(FAST_T, key);
      settle_segments(FAST_T);
    end else begin
      pos = locate(SLOW_T, key);
      if (pos >= 0) begin
        r.where  = WHERE_SLOW;
        r.decile = 4'(segment_at(SLOW_T, pos) + 1);
        slow_hits = bump(slow_hits);
        take_out(SLOW_T, pos);
        settle_segments(SLOW_T);
        if (admit(FAST_T, key, fast_cap, demoted))
          r.drop_v = admit(SLOW_T, demoted, slow_cap, gone);
      end else begin
        misses = bump(misses);
        r.drop_v = admit(SLOW_T, key, slow_cap, gone);
      end
    end
    if (r.drop_v) r.drop_k = gone;
    r.fast_n = fast_hits;
    r.slow_n = slow_hits;
    r.miss_n = misses;
    return r;
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    lookup_result_t e;
    if (!rst_n) begin
      awaited.delete();
      for (int t = 0; t < 2; t++)
        for (int s = 0; s < SEGS; s++) tier_seg[t][s] = 0;
      tier_depth[FAST_T] = 32;
      tier_depth[SLOW_T] = 256;
      fast_cap  = 32;
      slow_cap  = 256;
      fast_hits = '0;
      slow_hits = '0;
      misses    = '0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_FAST_CAP) fast_cap = int'(cfg_wdata[5:0]);
        else if (cfg_index == CFG_SLOW_CAP) slow_cap = int'(cfg_wdata);
      end
      if (in_valid && !in_stall) awaited.insert(awaited.size(), access(in_obj_key));
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("result transaction with no lookup outstanding");
          fail_count++;
        end else begin
          e = awaited.pop_front();
          if (out_where_found !== e.where) begin
            $error("where_found: expected %0d, got %0d", e.where, out_where_found);
            fail_count++;
          end
          if (out_hit_decile !== e.decile) begin
            $error("hit_decile: expected %0d, got %0d", e.decile, out_hit_decile);
            fail_count++;
          end
          if (out_dropped_valid !== e.drop_v) begin
            $error("dropped_valid: expected %0d, got %0d", e.drop_v, out_dropped_valid);
            fail_count++;
          end
          if (out_dropped_key !== e.drop_k) begin
            $error("dropped_key: expected %h, got %h", e.drop_k, out_dropped_key);
            fail_count++;
          end
          if (out_fast_hit_total !== e.fast_n) begin
            $error("fast_hit_total: expected %0d, got %0d", e.fast_n, out_fast_hit_total);
            fail_count++;
          end
          if (out_slow_hit_total !== e.slow_n) begin
            $error("slow_hit_total: expected %0d, got %0d", e.slow_n, out_slow_hit_total);
            fail_count++;
          end
          if (out_miss_total !== e.miss_n) begin
            $error("miss_total: expected %0d, got %0d", e.miss_n, out_miss_total);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the two-tier LRU core
// Drives key lookups and capacity settings with random idling and stalls;
// a checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import tlru_pkg::*;

  // Index past the register list; the core must ignore writes to it.
  localparam logic [7:0] CFG_UNUSED_IDX = 8'd2;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 200;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [KEY_W-1:0] in_obj_key = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_where_found;
  logic [3:0]       out_hit_decile;
  logic             out_dropped_valid;
  logic [KEY_W-1:0] out_dropped_key;
  logic [CNT_W-1:0] out_fast_hit_total, out_slow_hit_total, out_miss_total;
  logic             cfg_wr_en = 1'b0;
  logic [7:0]       cfg_index = '0;
  logic [8:0]       cfg_wdata = '0;
  int               pending, fail_count;

  // Idling percentages for each side and the request for one long hold-off.
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  bit               long_hold = 1'b0;
  int               cycles = 0;
  logic [KEY_W-1:0] key_pool[512];

  always #5 clk = ~clk;

  two_tier_lru_with_deciles_core dut (.*);

  tlru_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver stalls at random; on request it holds off for a long
  // stretch so that the core fills up and has to stall its own input.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        long_hold = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one key and holds it until the core accepts the transaction.
  task automatic send_key(input logic [KEY_W-1:0] key);
    int gap;
    in_valid   <= 1'b1;
    in_obj_key <= key;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  // One write; the enable is dropped again before anything else is driven.
  task automatic write_reg(input logic [7:0] idx, input logic [8:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Lets every outstanding result drain, then waits out the core's latency.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  // Mostly keys from a working set so that both tiers see hits at every
  // depth; the rest are fresh keys that miss.
  task automatic run_phase(input int fcap, input int scap, input int mode,
                           input int count, input int pool_size);
    logic [KEY_W-1:0] key;
    drain();
    write_reg(CFG_FAST_CAP, 9'(fcap));
    write_reg(CFG_SLOW_CAP, 9'(scap));
    for (int i = 0; i < pool_size; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) set_idling((mode + i / 50) % 4);
      if (mode == 2 && i == count / 2) long_hold = 1'b1;
      if ($urandom_range(99) < 78) key = key_pool[$urandom_range(pool_size - 1)];
      else key = {$urandom, $urandom};
      send_key(key);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme keys, key zero, hits in both tiers, then a tiny
    // fast tier so that demotion and slow-tier drops happen early.
    send_key('0);
    send_key('1);
    send_key('0);
    send_key('0);
    send_key('1);
    send_key('1);
    send_key({32{2'b10}});
    send_key({32{2'b01}});
    send_key({32{2'b10}});
    send_key({32{2'b01}});
    drain();
    write_reg(CFG_FAST_CAP, 9'd1);
    write_reg(CFG_SLOW_CAP, 9'd2);
    write_reg(CFG_UNUSED_IDX, 9'd0);
    send_key('0);
    send_key({32{2'b10}});
    send_key('1);
    send_key('0);
    send_key(64'd7);
    send_key(64'd8);
    send_key(64'd9);
    send_key({32{2'b01}});
    send_key(64'd7);
    send_key(64'd8);

    // Random phases over several capacity settings, extremes included:
    // zero, one, the maxima and values above the tier depths.
    run_phase(32, 256, 0, 260, 320);
    run_phase(1, 1, 1, 140, 6);
    run_phase(63, 511, 2, 260, 400);
    run_phase(0, 0, 3, 120, 5);
    run_phase(4, 20, 1, 200, 40);
    run_phase(12, 60, 2, 220, 90);
    run_phase(32, 256, 3, 230, 200);

    drain();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
